// File: hw/rtl/sma_pkg.sv
// Shared constants and types for the sensor moving average block.
// No dependencies; compile first.
package sma_pkg;

   // Default sizing of the block
   localparam int MAX_WINDOW_DEFAULT  = 16;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Window length register
   localparam int                     LENGTH_BITS  = 5;
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 5'd3;

   // Status of the divider, seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: hw/rtl/sma_if.sv
// Handshake channels of the sensor moving average block: sample in,
// average out and the window length write port. Depends on sma_pkg.

interface sma_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface sma_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

interface sma_csr_if
   import sma_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [LENGTH_BITS-1:0] window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

// File: hw/rtl/sma_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module sma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sma_divider.sv
// Bit-serial restoring divider: signed sum over unsigned window length,
// truncating toward zero, one quotient bit a cycle. Depends on sma_pkg.
module sma_divider
   import sma_pkg::*;
#(
   parameter int SUM_BITS    = 20,
   parameter int CNT_BITS    = 5,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_BITS-1:0]    dividend,
   input  logic [CNT_BITS-1:0]           divisor,
   output div_status_type                status,
   output logic signed [SAMPLE_BITS-1:0] quotient
);

   localparam int ITER_BITS = $clog2(SUM_BITS + 1);

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [ITER_BITS-1:0] iter_ff,  iter_in;
   logic [CNT_BITS-1:0]  rem_ff,   rem_in;
   logic [CNT_BITS-1:0]  dvs_ff,   dvs_in;
   logic [SUM_BITS-1:0]  quo_ff,   quo_in;
   logic                 neg_ff,   neg_in;

   logic [CNT_BITS:0]    rem_shift;
   logic [CNT_BITS:0]    rem_diff;
   logic [SUM_BITS-1:0]  magnitude;
   logic [SUM_BITS-1:0]  quo_signed;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_BITS-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      magnitude = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
   end

   // Sequence the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = ITER_BITS'(SUM_BITS);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = magnitude;
         neg_in  = dividend[SUM_BITS-1];
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = rem_diff[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         iter_in = iter_ff - 1'b1;
         if (iter_ff == ITER_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // Restore the sign; the mean always fits the sample width
   assign quo_signed  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient    = quo_signed[SAMPLE_BITS-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: hw/rtl/sensor_moving_average.sv
// Sensor moving average: one signed sample in, one average out per beat.
// Takes sma_pkg, sma_if, sma_ram and sma_divider.
//
// Each sample is written into a circular window held in a small RAM. The
// newest N samples (N = window_length, 0 read as 1, capped at MAX_WINDOW)
// are then read back one a cycle through the RAM's single read port and
// summed, and the sum is divided by N in a bit-serial restoring divider,
// one quotient bit a cycle, truncating toward zero. For odd N that mean is
// the result; for even N the result is the mean of this and the previous
// even-length mean, also truncated, and this mean is kept for next time.
// An item goes from one sample beat to the next through the read-and-add
// loop and the divider start, the divider on a SUM_BITS-wide sum
// (SUM_BITS = SAMPLE_BITS + clog2(MAX_WINDOW)), the load of the output
// register and the take of the next sample; a result register still
// occupied holds the final step until it is collected. req ready is high
// only while the block waits for a sample; a finished result waits in the
// output register, so the next sample is taken before it is collected.
// Window entries never written read as zero, tracked by one valid bit per
// entry; no clearing pass is needed after reset. The user must write
// window_length only while idle; the block itself does not enforce it.
module sensor_moving_average
   import sma_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sma_req_if.sink   req_chan,
   sma_rsp_if.source rsp_chan,
   sma_csr_if.sink   csr_chan
);

   localparam int PTR_BITS = $clog2(MAX_WINDOW);
   localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int EXT_BITS = SUM_BITS - SAMPLE_BITS;
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(MAX_WINDOW - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SUM    = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_HOLD   = 5'b10000
   } state_type;

   state_type                     state_ff,     state_in;
   logic [LENGTH_BITS-1:0]        length_ff,    length_in;
   logic [PTR_BITS-1:0]           head_ff,      head_in;
   logic [PTR_BITS-1:0]           rd_ptr_ff,    rd_ptr_in;
   logic [CNT_BITS-1:0]           n_ff,         n_in;
   logic [CNT_BITS-1:0]           remain_ff,    remain_in;
   logic [MAX_WINDOW-1:0]         written_ff,   written_in;
   logic                          rd_vld_ff,    rd_vld_in;
   logic                          entry_vld_ff, entry_vld_in;
   logic signed [SUM_BITS-1:0]    sum_ff,       sum_in;
   logic signed [SAMPLE_BITS-1:0] prev_ff,      prev_in;
   logic                          rsp_vld_ff,   rsp_vld_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff,  rsp_data_in;

   logic                          req_beat;
   logic                          rsp_beat;
   logic                          wr_en;
   logic                          rd_en;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic [PTR_BITS-1:0]           head_next;
   logic [CNT_BITS-1:0]           n_active;
   logic                          div_start;
   div_status_type                div_status;
   logic signed [SAMPLE_BITS-1:0] mean;
   logic signed [SAMPLE_BITS:0]   pair_sum;
   logic signed [SAMPLE_BITS:0]   pair_adj;
   logic signed [SAMPLE_BITS-1:0] result;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;

   // Configuration port, always ready. The user must write it only while idle; the block does not enforce it.
   assign csr_chan.ready = 1'b1;
   assign length_in = (csr_chan.valid) ? csr_chan.window_length : length_ff;

   // Clamp the configured length to 1 .. MAX_WINDOW
   always_comb begin
      if (length_ff == '0) begin
         n_active = CNT_BITS'(1);
      end else if (int'(length_ff) > MAX_WINDOW) begin
         n_active = CNT_BITS'(MAX_WINDOW);
      end else begin
         n_active = CNT_BITS'(length_ff);
      end
   end

   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;

   // Centred average of this and the previous mean, truncated toward zero
   always_comb begin
      pair_sum = {mean[SAMPLE_BITS-1], mean} + {prev_ff[SAMPLE_BITS-1], prev_ff};
      pair_adj = pair_sum + {{SAMPLE_BITS{1'b0}}, pair_sum[SAMPLE_BITS]};
      result   = n_ff[0] ? mean : pair_adj[SAMPLE_BITS:1];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      rd_ptr_in    = rd_ptr_ff;
      n_in         = n_ff;
      remain_in    = remain_ff;
      written_in   = written_ff;
      rd_vld_in    = 1'b0;
      entry_vld_in = entry_vld_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_beat;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // Store the sample at the new head of the window
            if (req_beat) begin
               wr_en               = 1'b1;
               head_in             = head_next;
               rd_ptr_in           = head_next;
               written_in[head_next] = 1'b1;
               n_in                = n_active;
               remain_in           = n_active;
               sum_in              = '0;
               state_in            = ST_SUM;
            end
         end
         ST_SUM: begin
            // Issue one read a cycle, newest first; add what came back
            if (remain_ff != '0) begin
               rd_en        = 1'b1;
               rd_vld_in    = 1'b1;
               entry_vld_in = written_ff[rd_ptr_ff];
               rd_ptr_in    = (rd_ptr_ff == '0) ? LAST_PTR : rd_ptr_ff - 1'b1;
               remain_in    = remain_ff - 1'b1;
            end
            if (rd_vld_ff && entry_vld_ff) begin
               sum_in = sum_ff + {{EXT_BITS{rd_data[SAMPLE_BITS-1]}}, rd_data};
            end
            if (remain_ff == '0 && !rd_vld_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Load the output register once it is free
            if (!rsp_vld_ff || rsp_beat) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = result;
               if (!n_ff[0]) begin
                  prev_in = mean;
               end
               state_in = ST_IDLE;
            end
         end
         ST_HOLD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         length_ff  <= LENGTH_RESET;
         head_ff    <= '0;
         written_ff <= '0;
         rd_vld_ff  <= 1'b0;
         remain_ff  <= '0;
         n_ff       <= CNT_BITS'(1);
         prev_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         length_ff  <= length_in;
         head_ff    <= head_in;
         written_ff <= written_in;
         rd_vld_ff  <= rd_vld_in;
         remain_ff  <= remain_in;
         n_ff       <= n_in;
         prev_ff    <= prev_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      entry_vld_ff <= entry_vld_in;
      sum_ff       <= sum_in;
      rsp_data_ff  <= rsp_data_in;
   end

   sma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_next),
      .wr_data (req_chan.sample),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   sma_divider #(
      .SUM_BITS    (SUM_BITS),
      .CNT_BITS    (CNT_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (n_ff),
      .status   (div_status),
      .quotient (mean)
   );

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_vld_ff;
   assign rsp_chan.average = rsp_data_ff;

   // Never restart the divider while it is working
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // Reads still owed never exceed the latched length
   a_remain_bounded: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= n_ff)
      else $error("read count exceeds window length");

   // An accepted sample goes straight into the summing loop
   a_beat_to_sum: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_SUM && n_ff != '0))
      else $error("accepted sample did not start summing");

   // A finished item with a free output register is presented next cycle
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_vld_ff || rsp_beat)) |=>
         (rsp_vld_ff && state_ff == ST_IDLE))
      else $error("result not loaded into output register");

endmodule
